### rtl/txcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// txcw_pkg
// Types, codes and constants shared by the text console writer modules.
// ----------------------------------------------------------------------------
package txcw_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  localparam int unsigned CELL_W = 16;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned IDX_W  = 11;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
  localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;
  localparam int unsigned       TAB_STEP   = 8;

  localparam logic [CHAR_W-1:0] CHAR_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_NL  = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_CR  = 8'd13;

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_BACK  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  cursor_position;
    logic [CELL_W-1:0] cell_value;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_item;
    logic exec_put;
    logic bs_move;
    logic bs_write;
    logic clear_start;
    logic sweep_write;
    logic blank_rst;
    logic read_issue;
    logic out_load;
  } txcw_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] mode;
    logic       put_scroll;
    logic       sweep_last;
    logic       out_free;
  } txcw_status_t;

endpackage
`default_nettype wire

### rtl/txcw_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// txcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module txcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/txcw_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// txcw_datapath
// Cursor, scroll offset, attribute register, screen RAM, blanking sweep and
// the output register of the text console writer.
// ----------------------------------------------------------------------------
module txcw_datapath #(
  parameter int unsigned COLUMNS = txcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = txcw_pkg::ROWS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire txcw_pkg::in_item_t            in_data_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [txcw_pkg::ATTR_W-1:0]   cfg_data_i,
  input  wire txcw_pkg::txcw_cmd_t           cmd_i,
  output txcw_pkg::txcw_status_t             status_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output txcw_pkg::out_item_t                out_data_o
);

  import txcw_pkg::*;

  localparam int unsigned NCELLS = ROWS * COLUMNS;
  localparam int unsigned AW     = $clog2(NCELLS);
  localparam int unsigned CLW    = $clog2(COLUMNS);
  localparam int unsigned RW     = $clog2(ROWS);
  // One bit above both the index and the address, so that the cell count
  // itself is representable even when it is a power of two.
  localparam int unsigned CW     = ((AW > IDX_W) ? AW : IDX_W) + 1;

  // The screen is a ring of rows: top_q is the physical address of the
  // first displayed row, so a scroll only moves top_q and blanks one row.
  function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] lin,
                                            input logic [AW-1:0] top);
    logic [AW:0] sum;
    sum = {1'b0, lin} + {1'b0, top};
    if (sum >= (AW+1)'(NCELLS)) begin
      sum = sum - (AW+1)'(NCELLS);
    end
    return sum[AW-1:0];
  endfunction

  in_item_t          item_q;
  logic [ATTR_W-1:0] attr_q;
  logic [CLW-1:0]    col_q, col_d;
  logic [RW-1:0]     row_q, row_d;
  logic [AW-1:0]     top_q;
  logic [AW-1:0]     sw_addr_q;
  logic [AW-1:0]     sw_end_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic [AW-1:0]     cur_lin;
  logic [AW-1:0]     cur_phys;
  logic [CLW:0]      col_inc;
  logic [CLW:0]      col_tab;
  logic [RW:0]       row_inc;
  logic [CLW:0]      put_col;
  logic [RW:0]       put_row;
  logic              put_scroll;
  logic              printable;
  logic [AW:0]       top_sum;
  logic [AW-1:0]     top_next;
  logic              idx_in_range;
  logic [CELL_W-1:0] blank_cell;
  logic [CELL_W-1:0] rdata;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;

  assign cur_lin  = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
  assign cur_phys = to_phys(cur_lin, top_q);

  assign col_inc = {1'b0, col_q} + (CLW+1)'(1);
  assign col_tab = ({1'b0, col_q} + (CLW+1)'(TAB_STEP)) & ~((CLW+1)'(TAB_STEP - 1));
  assign row_inc = {1'b0, row_q} + (RW+1)'(1);

  assign printable = (item_q.char_code != CHAR_NL) && (item_q.char_code != CHAR_CR) &&
                     (item_q.char_code != CHAR_TAB);

  // Cursor after a put, before the bottom-row check.
  always_comb begin
    put_col = {1'b0, col_q};
    put_row = {1'b0, row_q};
    if (item_q.char_code == CHAR_NL) begin
      put_col = '0;
      put_row = row_inc;
    end else if (item_q.char_code == CHAR_CR) begin
      put_col = '0;
    end else if (item_q.char_code == CHAR_TAB) begin
      if (col_tab >= (CLW+1)'(COLUMNS)) begin
        put_col = '0;
        put_row = row_inc;
      end else begin
        put_col = col_tab;
      end
    end else begin
      if (col_inc >= (CLW+1)'(COLUMNS)) begin
        put_col = '0;
        put_row = row_inc;
      end else begin
        put_col = col_inc;
      end
    end
  end

  assign put_scroll = (put_row >= (RW+1)'(ROWS));

  assign top_sum  = {1'b0, top_q} + (AW+1)'(COLUMNS);
  assign top_next = (top_sum >= (AW+1)'(NCELLS)) ? AW'(top_sum - (AW+1)'(NCELLS))
                                                  : top_sum[AW-1:0];

  // Cursor next state.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    priority if (cmd_i.clear_start) begin
      col_d = '0;
      row_d = '0;
    end else if (cmd_i.exec_put) begin
      col_d = put_col[CLW-1:0];
      row_d = put_scroll ? RW'(ROWS - 1) : put_row[RW-1:0];
    end else if (cmd_i.bs_move) begin
      if (col_q != '0) begin
        col_d = col_q - CLW'(1);
      end else if (row_q != '0) begin
        row_d = row_q - RW'(1);
        col_d = CLW'(COLUMNS - 1);
      end
    end
  end

  assign idx_in_range = (CW'(item_q.cell_index) < CW'(NCELLS));

  assign blank_cell = {(cmd_i.blank_rst ? RESET_ATTR : attr_q), SPACE_CODE};

  assign ram_we    = (cmd_i.exec_put && printable) || cmd_i.bs_write || cmd_i.sweep_write;
  assign ram_waddr = cmd_i.sweep_write ? sw_addr_q : cur_phys;
  assign ram_wdata = cmd_i.exec_put ? {attr_q, item_q.char_code} : blank_cell;

  txcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (NCELLS)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.read_issue && idx_in_range),
    .raddr_i (to_phys(AW'(item_q.cell_index), top_q)),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q      <= RESET_ATTR;
      col_q       <= '0;
      row_q       <= '0;
      top_q       <= '0;
      sw_addr_q   <= '0;
      sw_end_q    <= AW'(NCELLS - 1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        attr_q <= cfg_data_i;
      end
      col_q <= col_d;
      row_q <= row_d;
      if (cmd_i.clear_start) begin
        top_q     <= '0;
        sw_addr_q <= '0;
        sw_end_q  <= AW'(NCELLS - 1);
      end else if (cmd_i.exec_put && put_scroll) begin
        // The old top row becomes the new bottom row and is blanked.
        top_q     <= top_next;
        sw_addr_q <= top_q;
        sw_end_q  <= top_q + AW'(COLUMNS - 1);
      end else if (cmd_i.sweep_write) begin
        sw_addr_q <= sw_addr_q + AW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    if (cmd_i.out_load) begin
      out_q.cursor_position <= IDX_W'(cur_lin);
      out_q.cell_value      <= ((item_q.mode == MODE_READ) && idx_in_range) ? rdata : '0;
    end
  end

  assign status_o.mode       = item_q.mode;
  assign status_o.put_scroll = put_scroll;
  assign status_o.sweep_last = (sw_addr_q == sw_end_q);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

### rtl/txcw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// txcw_ctrl
// Sequencer of the text console writer: takes an item, steps the datapath
// through its mode and hands the result to the output register.
// ----------------------------------------------------------------------------
module txcw_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire txcw_pkg::txcw_status_t status_i,
  output txcw_pkg::txcw_cmd_t         cmd_o
);

  import txcw_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_BS_WR,
    S_SWEEP,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        // Reset fill of the screen with the power-on blank.
        cmd_o.sweep_write = 1'b1;
        cmd_o.blank_rst   = 1'b1;
        if (status_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (mode_e'(status_i.mode))
          MODE_PUT: begin
            cmd_o.exec_put = 1'b1;
            state_d        = status_i.put_scroll ? S_SWEEP : S_DONE;
          end
          MODE_BACK: begin
            cmd_o.bs_move = 1'b1;
            state_d       = S_BS_WR;
          end
          MODE_CLEAR: begin
            cmd_o.clear_start = 1'b1;
            state_d           = S_SWEEP;
          end
          MODE_READ: begin
            cmd_o.read_issue = 1'b1;
            state_d          = S_DONE;
          end
        endcase
      end
      S_BS_WR: begin
        cmd_o.bs_write = 1'b1;
        state_d        = S_DONE;
      end
      S_SWEEP: begin
        cmd_o.sweep_write = 1'b1;
        if (status_i.sweep_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule
`default_nettype wire

### rtl/text_console_writer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text console engine: character output with cursor, scroll, backspace,
// clear and cell readback over a screen RAM of COLUMNS x ROWS cells.
// ----------------------------------------------------------------------------
// After reset the block fills the screen RAM with blanks and accepts no item
// until that is done; the attribute register can be written meanwhile. An
// item goes from acceptance through an execute state and a done state for
// put, read and plain cursor moves; backspace adds a write state between
// them. A put that scrolls also blanks one row of COLUMNS cells and a clear
// blanks all ROWS*COLUMNS cells in a sweep state, because the blank fill goes
// through the single write port of the screen RAM one cell per cycle. A
// finished result waits in an output register, and the next item is taken
// meanwhile.
// ----------------------------------------------------------------------------
module text_console_writer_top #(
  parameter int unsigned COLUMNS = txcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = txcw_pkg::ROWS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire txcw_pkg::in_item_t          in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output txcw_pkg::out_item_t              out_data_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [txcw_pkg::ATTR_W-1:0] cfg_data_i
);

  import txcw_pkg::*;

  txcw_cmd_t    cmd;
  txcw_status_t status;

  assign cfg_ready_o = 1'b1;

  txcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  txcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // A new result is only loaded when the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over a pending result");

  // The controller drives at most one datapath action per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.exec_put, cmd.bs_move, cmd.bs_write, cmd.clear_start,
              cmd.sweep_write, cmd.read_issue, cmd.out_load, cmd.load_item}))
    else $error("conflicting datapath commands");

  // While an accepted item is in work, the block does not accept another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item accepted while another is in work");

  // The reset blank is only used by the power-on fill, never with an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.blank_rst |-> !in_ready_o)
    else $error("reset fill overlaps item handling");

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the text console writer. A mirror of the screen,
// the cursor and the attribute register predicts the result of every accepted
// item; a monitor compares each returned item with the oldest prediction while
// both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import txcw_pkg::*;

  localparam int unsigned COLS   = COLUMNS_DEF;
  localparam int unsigned LINES  = ROWS_DEF;
  localparam int unsigned NCELLS = COLS * LINES;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  in_item_t          in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  out_item_t         out_data_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [ATTR_W-1:0] cfg_data_i;

  // Mirror of the block state.
  logic [CELL_W-1:0] screen_mirror [NCELLS];
  int unsigned       cur_col;
  int unsigned       cur_row;
  logic [ATTR_W-1:0] attr_mirror;

  out_item_t   console_results_q[$];
  int unsigned snd_idle_pct = 15;
  int unsigned rcv_idle_pct = 86;
  int unsigned error_count  = 0;

  text_console_writer_top #(
    .COLUMNS(COLS),
    .ROWS   (LINES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [CELL_W-1:0] blank_cell();
    return {attr_mirror, SPACE_CODE};
  endfunction

  // Applies one item to the mirror and returns the result it should produce.
  function automatic out_item_t console_step(input in_item_t it);
    out_item_t res;
    res = '0;
    case (mode_e'(it.mode))
      MODE_PUT: begin
        if (it.char_code == CHAR_NL) begin
          cur_col = 0;
          cur_row++;
        end else if (it.char_code == CHAR_CR) begin
          cur_col = 0;
        end else if (it.char_code == CHAR_TAB) begin
          cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
          if (cur_col >= COLS) begin
            cur_col = 0;
            cur_row++;
          end
        end else begin
          screen_mirror[cur_row * COLS + cur_col] = {attr_mirror, it.char_code};
          cur_col++;
          if (cur_col >= COLS) begin
            cur_col = 0;
            cur_row++;
          end
        end
        // Past the bottom row the whole screen moves up by one row.
        if (cur_row >= LINES) begin
          for (int i = 0; i < NCELLS - COLS; i++) screen_mirror[i] = screen_mirror[i + COLS];
          for (int i = NCELLS - COLS; i < NCELLS; i++) screen_mirror[i] = blank_cell();
          cur_row = LINES - 1;
        end
      end
      MODE_BACK: begin
        if (cur_col > 0) begin
          cur_col--;
        end else if (cur_row > 0) begin
          cur_row--;
          cur_col = COLS - 1;
        end
        screen_mirror[cur_row * COLS + cur_col] = blank_cell();
      end
      MODE_CLEAR: begin
        foreach (screen_mirror[i]) screen_mirror[i] = blank_cell();
        cur_col = 0;
        cur_row = 0;
      end
      MODE_READ: begin
        if (it.cell_index < NCELLS) res.cell_value = screen_mirror[it.cell_index];
      end
    endcase
    res.cursor_position = IDX_W'(cur_row * COLS + cur_col);
    return res;
  endfunction

  // Mostly printable text with a fair share of line controls.
  function automatic logic [CHAR_W-1:0] pick_text_char();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return CHAR_W'($urandom_range(8'h7E, 8'h20));
    if (roll < 75) return CHAR_NL;
    if (roll < 80) return CHAR_CR;
    if (roll < 88) return CHAR_TAB;
    return CHAR_W'($urandom);
  endfunction

  // Reads favor the rows just written, so that scrolled text gets checked.
  function automatic logic [IDX_W-1:0] pick_read_index();
    int unsigned pos, back, roll;
    pos  = cur_row * COLS + cur_col;
    roll = $urandom_range(99);
    if (roll < 50) begin
      back = $urandom_range(3 * COLS);
      return IDX_W'((pos > back) ? pos - back : 0);
    end
    if (roll < 85) return IDX_W'($urandom_range(NCELLS - 1));
    return IDX_W'($urandom_range((1 << IDX_W) - 1));
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with
  // valid still high, so the next call either replaces the item or drops valid.
  task automatic send_console_item(input mode_e md, input logic [CHAR_W-1:0] ch,
                                   input logic [IDX_W-1:0] idx);
    in_item_t it;
    it.mode       = md;
    it.char_code  = ch;
    it.cell_index = idx;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    console_results_q.push_back(console_step(it));
    @(negedge clk_i);
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (console_results_q.size() != 0);
  endtask

  task automatic write_text_attribute(input logic [ATTR_W-1:0] value);
    wait_results_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    attr_mirror = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_contents();
    send_console_item(MODE_READ, CHAR_W'($urandom), '0);
    send_console_item(MODE_READ, CHAR_W'($urandom), IDX_W'(NCELLS - 1));
    send_console_item(MODE_READ, CHAR_W'($urandom), IDX_W'(NCELLS));
    send_console_item(MODE_READ, CHAR_W'($urandom), '1);
  endtask

  task automatic test_cursor_controls();
    write_text_attribute(8'hFF);
    send_console_item(MODE_PUT, 8'h00, IDX_W'($urandom));
    send_console_item(MODE_PUT, 8'hFF, IDX_W'($urandom));
    send_console_item(MODE_PUT, CHAR_TAB, IDX_W'($urandom));
    send_console_item(MODE_PUT, CHAR_CR, IDX_W'($urandom));
    send_console_item(MODE_PUT, CHAR_NL, IDX_W'($urandom));
    // Backspace at column 0 goes to the last column of the row above.
    send_console_item(MODE_BACK, CHAR_W'($urandom), IDX_W'($urandom));
    send_console_item(MODE_PUT, 8'h41, IDX_W'($urandom));
    send_console_item(MODE_READ, CHAR_W'($urandom), IDX_W'(COLS - 1));
    send_console_item(MODE_BACK, CHAR_W'($urandom), IDX_W'($urandom));
    send_console_item(MODE_PUT, CHAR_TAB, IDX_W'($urandom));
    send_console_item(MODE_READ, CHAR_W'($urandom), '0);
    send_console_item(MODE_READ, CHAR_W'($urandom), IDX_W'(1));
    write_text_attribute(8'h00);
    send_console_item(MODE_CLEAR, CHAR_W'($urandom), IDX_W'($urandom));
    send_console_item(MODE_READ, CHAR_W'($urandom), IDX_W'(NCELLS - 1));
    // Backspace at home stays put and blanks the first cell.
    send_console_item(MODE_PUT, 8'h58, IDX_W'($urandom));
    send_console_item(MODE_PUT, CHAR_CR, IDX_W'($urandom));
    send_console_item(MODE_BACK, CHAR_W'($urandom), IDX_W'($urandom));
    send_console_item(MODE_READ, CHAR_W'($urandom), '0);
  endtask

  task automatic test_text_with_scroll(input int unsigned n);
    int unsigned roll;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (roll < 72) begin
        send_console_item(MODE_PUT, pick_text_char(), IDX_W'($urandom));
      end else if (roll < 80) begin
        send_console_item(MODE_BACK, CHAR_W'($urandom), IDX_W'($urandom));
      end else if (roll < 99) begin
        send_console_item(MODE_READ, CHAR_W'($urandom), pick_read_index());
      end else begin
        send_console_item(MODE_CLEAR, CHAR_W'($urandom), IDX_W'($urandom));
      end
    end
  endtask

  // Text runs followed by backspace runs that cross rows and often reach home.
  task automatic test_backspace_runs(input int unsigned n);
    int unsigned sent, run;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(3) == 0) begin
        send_console_item(MODE_CLEAR, CHAR_W'($urandom), IDX_W'($urandom));
        sent++;
      end
      run = $urandom_range(60, 1);
      repeat (run) send_console_item(MODE_PUT, pick_text_char(), IDX_W'($urandom));
      sent += run;
      run = $urandom_range(90, 1);
      repeat (run) begin
        send_console_item(MODE_BACK, CHAR_W'($urandom), IDX_W'($urandom));
        sent++;
        if ($urandom_range(3) == 0) begin
          send_console_item(MODE_READ, CHAR_W'($urandom), pick_read_index());
          sent++;
        end
      end
    end
  endtask

  task automatic test_random_noise(input int unsigned n);
    int unsigned roll;
    for (int k = 0; k < n; k++) begin
      // Halfway through, the sender holds off until the pipeline is empty.
      if (k == n / 2) wait_results_drained();
      roll = $urandom_range(99);
      if (roll < 2) begin
        send_console_item(MODE_CLEAR, CHAR_W'($urandom), IDX_W'($urandom));
      end else begin
        send_console_item(mode_e'($urandom_range(2) == 2 ? MODE_READ :
                                  $urandom_range(1)),
                          CHAR_W'($urandom), IDX_W'($urandom));
      end
    end
  endtask

  initial begin : result_receiver
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  initial begin : result_monitor
    out_item_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
        if (console_results_q.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: unexpected result cursor=%0d cell=%h", $realtime,
                     out_data_o.cursor_position, out_data_o.cell_value);
        end else begin
          want = console_results_q.pop_front();
          if (out_data_o.cursor_position !== want.cursor_position ||
              out_data_o.cell_value !== want.cell_value) begin
            error_count++;
            if (error_count <= 10)
              $display("%0t: mismatch cursor exp=%0d got=%0d, cell exp=%h got=%h",
                       $realtime, want.cursor_position, out_data_o.cursor_position,
                       want.cell_value, out_data_o.cell_value);
          end
        end
      end
    end
  end

  // Far beyond the slowest correct run, reset fill included.
  initial begin : run_limit
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    attr_mirror = RESET_ATTR;
    foreach (screen_mirror[i]) screen_mirror[i] = {RESET_ATTR, SPACE_CODE};
    cur_col = 0;
    cur_row = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset contents are read before any attribute write; the first read is
    // offered while the block may still be running its blank fill.
    test_reset_contents();
    test_cursor_controls();
    write_text_attribute(ATTR_W'($urandom));
    test_text_with_scroll(650);

    snd_idle_pct = 86;
    rcv_idle_pct = 15;
    write_text_attribute(ATTR_W'($urandom));
    test_backspace_runs(500);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_text_attribute(8'hFF);
    test_random_noise(450);
    write_text_attribute(RESET_ATTR);
    test_text_with_scroll(250);

    wait_results_drained();
    repeat (16) @(posedge clk_i);
    if (error_count == 0 && console_results_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
